@@ rtl/utf8_to_glyph_code_mapper_macros.svh @@
// Assertion macros used by the glyph mapper top level.
`ifndef UTF8_TO_GLYPH_CODE_MAPPER_MACROS_SVH
`define UTF8_TO_GLYPH_CODE_MAPPER_MACROS_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define U2G_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define U2G_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/u2g_pkg.sv @@
// Package: decoder state, result types and the shared checkerboard glyph constant.
`timescale 1ns / 1ps

package u2g_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WAIT  = 3'd1,
		MODE_SKIP  = 3'd2,
		MODE_STRAY = 3'd3
	} mode_t;

	localparam logic [7:0] CHECKER_CODE = 8'd127;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] lead;
		logic [7:0] first;
		logic [7:0] second;
		logic [1:0] rem;
	} decode_state_t;

	// First code of a run and the run length; later codes are always checkerboard
	typedef struct packed {
		logic [7:0] code;
		logic [1:0] count;
	} decode_result_t;

	localparam decode_state_t STATE_RESET = '{
		mode:   MODE_IDLE,
		lead:   8'h00,
		first:  8'h00,
		second: 8'h00,
		rem:    2'd0
	};

endpackage

@@ rtl/u2g_byte_if.sv @@
// Byte input channel: valid/ready handshake carrying one message byte.
`timescale 1ns / 1ps

interface u2g_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       msg_last;

	modport source (output valid, output byte_in, output msg_last, input ready);
	modport sink (input valid, input byte_in, input msg_last, output ready);
endinterface

@@ rtl/u2g_glyph_if.sv @@
// Glyph output channel: valid/ready handshake carrying one display code.
`timescale 1ns / 1ps

interface u2g_glyph_if;
	logic       valid;
	logic       ready;
	logic [7:0] glyph_code;
	logic       run_last;

	modport source (output valid, output glyph_code, output run_last, input ready);
	modport sink (input valid, input glyph_code, input run_last, output ready);
endinterface

@@ rtl/u2g_decode.sv @@
// Combinational byte decoder: next decoder state and the code run for one byte.
`timescale 1ns / 1ps

module u2g_decode (
	input  logic [7:0]              byte_in,
	input  logic                    msg_last,
	input  u2g_pkg::decode_state_t  state_cur,
	output u2g_pkg::decode_state_t  state_nxt,
	output u2g_pkg::decode_result_t result
);

	localparam logic [7:0] SPACE_CODE = 8'd32;
	localparam logic [7:0] LF_BYTE    = 8'h0A;
	localparam logic [7:0] LEAD_C2    = 8'hC2;
	localparam logic [7:0] LEAD_C3    = 8'hC3;
	localparam logic [7:0] LEAD_C4    = 8'hC4;
	localparam logic [7:0] LEAD_C5    = 8'hC5;
	localparam logic [7:0] LEAD_E2    = 8'hE2;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] C3_OFFSET  = 8'd64;

	// Bytes that follow a known lead byte
	function automatic logic [1:0] follow_count(input logic [7:0] lead);
		logic [1:0] n;
		n = 2'd1;
		if (lead == LEAD_E2) n = 2'd2;
		if (lead == LEAD_F0) n = 2'd3;
		return n;
	endfunction

	// Map a complete known sequence to its glyph code
	function automatic logic [7:0] resolve(input logic [7:0] lead, input logic [7:0] f1,
			input logic [7:0] f2, input logic [7:0] f3);
		logic [7:0] c;
		c = u2g_pkg::CHECKER_CODE;
		case (lead)
			LEAD_C3: begin
				c = f1 + C3_OFFSET;
			end
			LEAD_C2: begin
				case (f1)
					8'h86:   c = 8'd134;
					8'h87:   c = 8'd135;
					8'h89:   c = 8'd137;
					8'hA0:   c = 8'd129;
					8'hA7:   c = 8'd167;
					8'hB0:   c = 8'd176;
					8'hB1:   c = 8'd177;
					8'hB2:   c = 8'd178;
					8'hB3:   c = 8'd179;
					8'hB5:   c = 8'd181;
					8'hB9:   c = 8'd185;
					8'hBA:   c = 8'd186;
					default: c = u2g_pkg::CHECKER_CODE;
				endcase
			end
			LEAD_C4: begin
				case (f1)
					8'h8C:   c = 8'd142;
					8'h8D:   c = 8'd157;
					default: c = u2g_pkg::CHECKER_CODE;
				endcase
			end
			LEAD_C5: begin
				case (f1)
					8'hA0:   c = 8'd138;
					8'hA1:   c = 8'd154;
					8'hBD:   c = 8'd143;
					8'hBE:   c = 8'd158;
					default: c = u2g_pkg::CHECKER_CODE;
				endcase
			end
			LEAD_E2: begin
				if (f1 == 8'h82 && f2 == 8'hAC) begin
					c = 8'd128;
				end else if (f1 == 8'h80) begin
					case (f2)
						8'h93:   c = 8'd150;
						8'h94:   c = 8'd151;
						8'hA2:   c = 8'd183;
						8'hA6:   c = 8'd133;
						8'hB0:   c = 8'd137;
						default: c = u2g_pkg::CHECKER_CODE;
					endcase
				end
			end
			LEAD_F0: begin
				if (f1 == 8'h9F && f2 == 8'h90 && f3 == 8'hB1) c = 8'd129;
			end
			default: begin
				c = u2g_pkg::CHECKER_CODE;
			end
		endcase
		return c;
	endfunction

	u2g_pkg::mode_t st_mode;
	logic [7:0]     st_lead;
	logic [1:0]     st_rem;
	logic [7:0]     st_code;
	logic [1:0]     st_cnt;

	logic [1:0]     need;
	logic [1:0]     rem_eff;
	logic [1:0]     pos;
	logic [7:0]     f1;
	logic [7:0]     f2;

	// Decode a byte that opens a new sequence
	always_comb begin
		st_mode = u2g_pkg::MODE_IDLE;
		st_lead = state_cur.lead;
		st_rem  = state_cur.rem;
		st_code = u2g_pkg::CHECKER_CODE;
		st_cnt  = 2'd0;
		if (!byte_in[7]) begin
			st_cnt = 2'd1;
			if (byte_in == 8'h00 || byte_in == LF_BYTE) begin
				st_code = SPACE_CODE;
			end else if (byte_in < SPACE_CODE) begin
				st_code = u2g_pkg::CHECKER_CODE;
			end else begin
				st_code = byte_in;
			end
		end else if (byte_in[7:5] == 3'b110) begin
			st_rem = 2'd1;
			if (byte_in >= LEAD_C2 && byte_in <= LEAD_C5) begin
				st_mode = u2g_pkg::MODE_WAIT;
				st_lead = byte_in;
			end else begin
				st_mode = u2g_pkg::MODE_SKIP;
				st_cnt  = 2'd1;
			end
		end else if (byte_in[7:4] == 4'b1110) begin
			st_rem = 2'd2;
			if (byte_in == LEAD_E2) begin
				st_mode = u2g_pkg::MODE_WAIT;
				st_lead = byte_in;
			end else begin
				st_mode = u2g_pkg::MODE_SKIP;
				st_cnt  = 2'd2;
			end
		end else if (byte_in[7:3] == 5'b11110) begin
			st_rem = 2'd3;
			if (byte_in == LEAD_F0) begin
				st_mode = u2g_pkg::MODE_WAIT;
				st_lead = byte_in;
			end else begin
				st_mode = u2g_pkg::MODE_SKIP;
				st_cnt  = 2'd3;
			end
		end else begin
			st_mode = u2g_pkg::MODE_STRAY;
		end
	end

	// Position of this byte within a pending sequence
	always_comb begin
		need    = follow_count(state_cur.lead);
		rem_eff = (state_cur.rem == 2'd0 || state_cur.rem > need) ? 2'd1 : state_cur.rem;
		pos     = need - rem_eff;
		f1      = (pos == 2'd0) ? byte_in : state_cur.first;
		f2      = (pos == 2'd1) ? byte_in : state_cur.second;
	end

	// Advance the decoder and form the code run
	always_comb begin
		state_nxt    = state_cur;
		result.code  = u2g_pkg::CHECKER_CODE;
		result.count = 2'd0;
		case (state_cur.mode)
			u2g_pkg::MODE_WAIT: begin
				state_nxt.first  = f1;
				state_nxt.second = f2;
				if (rem_eff <= 2'd1) begin
					result.code    = resolve(state_cur.lead, f1, f2, byte_in);
					result.count   = 2'd1;
					state_nxt.mode = u2g_pkg::MODE_IDLE;
					state_nxt.rem  = 2'd0;
				end else begin
					state_nxt.rem = rem_eff - 2'd1;
				end
			end
			u2g_pkg::MODE_SKIP: begin
				if (state_cur.rem <= 2'd1) begin
					state_nxt.mode = u2g_pkg::MODE_IDLE;
					state_nxt.rem  = 2'd0;
				end else begin
					state_nxt.rem = state_cur.rem - 2'd1;
				end
			end
			u2g_pkg::MODE_STRAY: begin
				if (byte_in[7]) begin
					result.count = 2'd1;
				end else begin
					state_nxt.mode = st_mode;
					state_nxt.lead = st_lead;
					state_nxt.rem  = st_rem;
					result.code    = st_code;
					result.count   = st_cnt;
				end
			end
			default: begin
				state_nxt.mode = st_mode;
				state_nxt.lead = st_lead;
				state_nxt.rem  = st_rem;
				result.code    = st_code;
				result.count   = st_cnt;
			end
		endcase

		// Flush a truncated sequence at the end of the message and drop all state
		if (msg_last) begin
			if (state_nxt.mode == u2g_pkg::MODE_WAIT) begin
				result.code  = u2g_pkg::CHECKER_CODE;
				result.count = follow_count(state_nxt.lead);
			end
			state_nxt = u2g_pkg::STATE_RESET;
		end
	end

endmodule

@@ rtl/utf8_to_glyph_code_mapper.sv @@
// Top level: message bytes in, display glyph codes out.
//
//  channel        modport  payload                 direction
//  byte_stream    sink     byte_in[7:0], msg_last  bytes in
//  glyph_stream   source   glyph_code[7:0], run_last  codes out
//
// A byte is registered on acceptance and decoded into the result register once it is free.
// One byte per cycle is taken while bytes yield at most one code and glyph_stream is ready.
// A k-code byte holds the result register till all are sent, one per cycle while ready.
// Bytes that yield no code pass the decoder without touching the result register.
// arst_n clears decoder state, both valid flags; send no byte in reset, it is not blocked.
// Backpressure on glyph_stream stalls the byte register, then byte_stream.ready.
`timescale 1ns / 1ps
`include "utf8_to_glyph_code_mapper_macros.svh"

module utf8_to_glyph_code_mapper (
	input  logic        clk,
	input  logic        arst_n,
	u2g_byte_if.sink    byte_stream,
	u2g_glyph_if.source glyph_stream
);

	logic [7:0]              byte_s1;
	logic                    last_s1;
	logic                    valid_s1;

	logic [7:0]              code_s2;
	logic [1:0]              cnt_s2;
	logic [1:0]              idx_s2;
	logic                    valid_s2;

	u2g_pkg::decode_state_t  state_q;
	u2g_pkg::decode_state_t  state_nxt;
	u2g_pkg::decode_result_t dec_res;

	logic                    run_end;
	logic                    s2_free;
	logic                    s1_adv;

	u2g_decode u_decode (
		.byte_in   (byte_s1),
		.msg_last  (last_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (dec_res)
	);

	// Handshake control between the two register stages
	always_comb begin
		run_end           = (idx_s2 == cnt_s2 - 2'd1);
		s2_free           = !valid_s2 || (glyph_stream.ready && run_end);
		s1_adv            = valid_s1 && (dec_res.count == 2'd0 || s2_free);
		byte_stream.ready = !valid_s1 || s1_adv;
	end

	// Hold the accepted byte until the decoder can hand on its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.byte_in;
			last_s1 <= byte_stream.msg_last;
		end
	end

	// Advance the decoder state once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2g_pkg::STATE_RESET;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// Load a new code run, or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (s1_adv && dec_res.count != 2'd0) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
		end else if (valid_s2 && glyph_stream.ready) begin
			if (run_end) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && dec_res.count != 2'd0) begin
			code_s2 <= dec_res.code;
			cnt_s2  <= dec_res.count;
		end
	end

	// Drive the output transaction
	always_comb begin
		glyph_stream.valid      = valid_s2;
		glyph_stream.glyph_code = (idx_s2 == 2'd0) ? code_s2 : u2g_pkg::CHECKER_CODE;
		glyph_stream.run_last   = run_end;
	end

	`U2G_ASSERT_NOW(a_run_nonempty, valid_s2, cnt_s2 != 2'd0, "empty code run in result register")
	`U2G_ASSERT_NOW(a_idx_in_run, valid_s2, idx_s2 < cnt_s2, "run index beyond run length")
	`U2G_ASSERT_NEXT(a_run_continues, valid_s2 && glyph_stream.ready && !run_end, valid_s2 && idx_s2 == $past(idx_s2) + 2'd1, "code run cut short")
	`U2G_ASSERT_NEXT(a_s1_holds, valid_s1 && !s1_adv, valid_s1 && $stable(byte_s1) && $stable(last_s1), "stalled byte lost or changed")
	`U2G_ASSERT_NOW(a_wait_pending, state_q.mode == u2g_pkg::MODE_WAIT, state_q.rem != 2'd0, "waiting for follow bytes with none outstanding")

endmodule

@@ sim/tb_utf8_to_glyph_code_mapper.sv @@
// Testbench for the UTF-8 to glyph code mapper: byte stimulus, predicted codes, checking.
`timescale 1ns / 1ps

module tb_utf8_to_glyph_code_mapper;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 5;
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PHASE_ITEMS     = 28;

	// Character and lead byte values the mapping treats specially
	localparam logic [7:0] ASCII_NUL         = 8'h00;
	localparam logic [7:0] ASCII_LF          = 8'h0A;
	localparam logic [7:0] FIRST_PRINTABLE   = 8'h20;
	localparam logic [7:0] GLYPH_SPACE       = 8'd32;
	localparam logic [7:0] LATIN1_OFFSET     = 8'd64;
	localparam logic [7:0] LEAD_SYMBOLS      = 8'hC2;
	localparam logic [7:0] LEAD_LATIN1       = 8'hC3;
	localparam logic [7:0] LEAD_LATIN_A_LOW  = 8'hC4;
	localparam logic [7:0] LEAD_LATIN_A_HIGH = 8'hC5;
	localparam logic [7:0] LEAD_PUNCT        = 8'hE2;
	localparam logic [7:0] LEAD_EMOJI        = 8'hF0;

	typedef struct packed {
		logic [7:0] code;
		logic       run_last;
	} glyph_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} plan_item_t;

	// Predicts the glyph codes of each accepted byte and checks the codes that come out
	class glyph_predictor;
		u2g_pkg::mode_t mode;
		logic [7:0]     held_lead;
		logic [7:0]     follow1;
		logic [7:0]     follow2;
		logic [1:0]     bytes_left;
		logic [7:0]     run_codes[$];
		glyph_t         expected_glyphs[$];
		int             error_count;

		function new();
			error_count = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode = u2g_pkg::MODE_IDLE;
			held_lead = 8'h00;
			follow1 = 8'h00;
			follow2 = 8'h00;
			bytes_left = 2'd0;
		endfunction

		function logic [1:0] follow_count(logic [7:0] lead);
			if (lead == LEAD_PUNCT)
				return 2'd2;
			if (lead == LEAD_EMOJI)
				return 2'd3;
			return 2'd1;
		endfunction

		// A run never holds more than three codes
		function void emit(logic [7:0] code);
			if (run_codes.size() < 3)
				run_codes.push_back(code);
		endfunction

		// Resolve a complete sequence through the fixed tables
		function logic [7:0] resolve_run(logic [7:0] last_data);
			case (held_lead)
				LEAD_LATIN1: return follow1 + LATIN1_OFFSET;
				LEAD_SYMBOLS: begin
					case (follow1)
						8'h86: return 8'd134;
						8'h87: return 8'd135;
						8'h89: return 8'd137;
						8'hA0: return 8'd129;
						8'hA7: return 8'd167;
						8'hB0: return 8'd176;
						8'hB1: return 8'd177;
						8'hB2: return 8'd178;
						8'hB3: return 8'd179;
						8'hB5: return 8'd181;
						8'hB9: return 8'd185;
						8'hBA: return 8'd186;
						default: return u2g_pkg::CHECKER_CODE;
					endcase
				end
				LEAD_LATIN_A_LOW: begin
					if (follow1 == 8'h8C)
						return 8'd142;
					if (follow1 == 8'h8D)
						return 8'd157;
					return u2g_pkg::CHECKER_CODE;
				end
				LEAD_LATIN_A_HIGH: begin
					case (follow1)
						8'hA0: return 8'd138;
						8'hA1: return 8'd154;
						8'hBD: return 8'd143;
						8'hBE: return 8'd158;
						default: return u2g_pkg::CHECKER_CODE;
					endcase
				end
				LEAD_PUNCT: begin
					if (follow1 == 8'h82 && follow2 == 8'hAC)
						return 8'd128;
					if (follow1 == 8'h80) begin
						case (follow2)
							8'h93: return 8'd150;
							8'h94: return 8'd151;
							8'hA2: return 8'd183;
							8'hA6: return 8'd133;
							8'hB0: return 8'd137;
							default: return u2g_pkg::CHECKER_CODE;
						endcase
					end
					return u2g_pkg::CHECKER_CODE;
				end
				LEAD_EMOJI: begin
					if (follow1 == 8'h9F && follow2 == 8'h90 && last_data == 8'hB1)
						return 8'd129;
					return u2g_pkg::CHECKER_CODE;
				end
				default: return u2g_pkg::CHECKER_CODE;
			endcase
		endfunction

		// Decode a byte at the start of a sequence
		function void start_sequence(logic [7:0] data);
			mode = u2g_pkg::MODE_IDLE;
			if (!data[7]) begin
				if (data == ASCII_NUL || data == ASCII_LF)
					emit(GLYPH_SPACE);
				else if (data < FIRST_PRINTABLE)
					emit(u2g_pkg::CHECKER_CODE);
				else
					emit(data);
			end else if (data[7:5] == 3'b110) begin
				if (data >= LEAD_SYMBOLS && data <= LEAD_LATIN_A_HIGH) begin
					mode = u2g_pkg::MODE_WAIT;
					held_lead = data;
					bytes_left = 2'd1;
				end else begin
					emit(u2g_pkg::CHECKER_CODE);
					mode = u2g_pkg::MODE_SKIP;
					bytes_left = 2'd1;
				end
			end else if (data[7:4] == 4'hE) begin
				if (data == LEAD_PUNCT) begin
					mode = u2g_pkg::MODE_WAIT;
					held_lead = data;
					bytes_left = 2'd2;
				end else begin
					repeat (2) emit(u2g_pkg::CHECKER_CODE);
					mode = u2g_pkg::MODE_SKIP;
					bytes_left = 2'd2;
				end
			end else if (data[7:3] == 5'b11110) begin
				if (data == LEAD_EMOJI) begin
					mode = u2g_pkg::MODE_WAIT;
					held_lead = data;
					bytes_left = 2'd3;
				end else begin
					repeat (3) emit(u2g_pkg::CHECKER_CODE);
					mode = u2g_pkg::MODE_SKIP;
					bytes_left = 2'd3;
				end
			end else begin
				// continuation byte or F8 and above at a sequence start
				mode = u2g_pkg::MODE_STRAY;
			end
		endfunction

		// Advance the decoder by one accepted byte and queue the codes it causes
		function void note_byte(logic [7:0] data, logic is_last);
			logic [1:0] need;
			logic [1:0] rem_now;
			logic [1:0] pos;
			glyph_t     g;
			run_codes.delete();
			case (mode)
				u2g_pkg::MODE_WAIT: begin
					need = follow_count(held_lead);
					rem_now = bytes_left;
					if (rem_now == 2'd0 || rem_now > need)
						rem_now = 2'd1;
					pos = need - rem_now;
					if (pos == 2'd0)
						follow1 = data;
					else if (pos == 2'd1)
						follow2 = data;
					if (rem_now <= 2'd1) begin
						emit(resolve_run(data));
						mode = u2g_pkg::MODE_IDLE;
						bytes_left = 2'd0;
					end else begin
						bytes_left = rem_now - 2'd1;
					end
				end
				u2g_pkg::MODE_SKIP: begin
					if (bytes_left <= 2'd1) begin
						mode = u2g_pkg::MODE_IDLE;
						bytes_left = 2'd0;
					end else begin
						bytes_left = bytes_left - 2'd1;
					end
				end
				u2g_pkg::MODE_STRAY: begin
					if (data[7])
						emit(u2g_pkg::CHECKER_CODE);
					else
						start_sequence(data);
				end
				default: start_sequence(data);
			endcase
			// A message cut short mid-sequence gives checkerboards; skips and strays drop
			if (is_last) begin
				if (mode == u2g_pkg::MODE_WAIT)
					repeat (follow_count(held_lead)) emit(u2g_pkg::CHECKER_CODE);
				clear_state();
			end
			foreach (run_codes[i]) begin
				g.code = run_codes[i];
				g.run_last = (i == run_codes.size() - 1);
				expected_glyphs.push_back(g);
			end
		endfunction

		function int pending();
			return expected_glyphs.size();
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			error_count++;
		endtask

		// Compare one transaction on the glyph channel with the oldest prediction
		task check_glyph(logic [7:0] code, logic run_last);
			glyph_t want;
			if (expected_glyphs.size() == 0) begin
				report_mismatch($sformatf("unexpected glyph code %0d run_last %0b", code,
					run_last));
			end else begin
				want = expected_glyphs.pop_front();
				if (code !== want.code)
					report_mismatch($sformatf("glyph_code %0d, predicted %0d", code,
						want.code));
				if (run_last !== want.run_last)
					report_mismatch($sformatf("run_last %0b, predicted %0b for code %0d",
						run_last, want.run_last, want.code));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	u2g_byte_if  byte_ch ();
	u2g_glyph_if glyph_ch ();

	utf8_to_glyph_code_mapper DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_ch),
		.glyph_stream (glyph_ch)
	);

	glyph_predictor glyph_model = new();

	int         src_idle_pct;
	int         rcv_idle_pct;
	bit         stall_request;
	int         stuck_cycles;
	int         items_sent;
	logic [7:0] draft[$];
	plan_item_t byte_plan[$];

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Check every glyph transaction at the rising edge
	always @(posedge clk) begin
		if (arst_n && glyph_ch.valid && glyph_ch.ready)
			glyph_model.check_glyph(glyph_ch.glyph_code, glyph_ch.run_last);
	end

	// Count cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (glyph_ch.valid && glyph_ch.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= STALL_LIMIT);
		$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Glyph receiver: random stalls, plus one long hold-off on request
	initial begin
		glyph_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				glyph_ch.ready <= 1'b0;
				stall_request = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				glyph_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offer one byte, idling at random first; entered and left at a falling edge
	task automatic send_item(input logic [7:0] data, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			byte_ch.byte_in <= 8'($urandom);
			byte_ch.msg_last <= 1'($urandom);
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= data;
		byte_ch.msg_last <= is_last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		glyph_model.note_byte(data, is_last);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every predicted code has arrived
	task automatic wait_for_drain();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (glyph_model.pending() > 0) @(negedge clk);
	endtask

	// Build a recognised sequence into draft, sometimes with one follow byte corrupted
	task automatic draft_known_sequence();
		draft.delete();
		case ($urandom_range(5))
			0: begin
				draft.push_back(LEAD_SYMBOLS);
				case ($urandom_range(11))
					0: draft.push_back(8'h86);
					1: draft.push_back(8'h87);
					2: draft.push_back(8'h89);
					3: draft.push_back(8'hA0);
					4: draft.push_back(8'hA7);
					5: draft.push_back(8'hB0);
					6: draft.push_back(8'hB1);
					7: draft.push_back(8'hB2);
					8: draft.push_back(8'hB3);
					9: draft.push_back(8'hB5);
					10: draft.push_back(8'hB9);
					default: draft.push_back(8'hBA);
				endcase
			end
			1: begin
				draft.push_back(LEAD_LATIN1);
				draft.push_back(8'($urandom_range(255)));
			end
			2: begin
				draft.push_back(LEAD_LATIN_A_LOW);
				draft.push_back($urandom_range(1) ? 8'h8C : 8'h8D);
			end
			3: begin
				draft.push_back(LEAD_LATIN_A_HIGH);
				case ($urandom_range(3))
					0: draft.push_back(8'hA0);
					1: draft.push_back(8'hA1);
					2: draft.push_back(8'hBD);
					default: draft.push_back(8'hBE);
				endcase
			end
			4: begin
				draft.push_back(LEAD_PUNCT);
				case ($urandom_range(5))
					0: begin draft.push_back(8'h82); draft.push_back(8'hAC); end
					1: begin draft.push_back(8'h80); draft.push_back(8'h93); end
					2: begin draft.push_back(8'h80); draft.push_back(8'h94); end
					3: begin draft.push_back(8'h80); draft.push_back(8'hA2); end
					4: begin draft.push_back(8'h80); draft.push_back(8'hA6); end
					default: begin draft.push_back(8'h80); draft.push_back(8'hB0); end
				endcase
			end
			default: begin
				draft.push_back(LEAD_EMOJI);
				draft.push_back(8'h9F);
				draft.push_back(8'h90);
				draft.push_back(8'hB1);
			end
		endcase
		// Miss the table now and then, mostly with another continuation byte
		if ($urandom_range(99) < 40)
			draft[$urandom_range(1, draft.size() - 1)] = ($urandom_range(3) == 0) ?
				8'($urandom_range(255)) : 8'($urandom_range(8'h80, 8'hBF));
	endtask

	// Plan one random sequence of bytes into byte_plan
	task automatic plan_sequence();
		int         pick;
		int         keep;
		int         n;
		logic [7:0] lead;
		logic       force_last;
		plan_item_t item;
		force_last = 1'b0;
		draft.delete();
		pick = $urandom_range(99);
		if (pick < 20) begin
			draft.push_back(8'($urandom_range(127)));
		end else if (pick < 55) begin
			draft_known_sequence();
		end else if (pick < 68) begin
			// unsupported lead: its follow bytes may hold any value
			lead = 8'($urandom_range(8'hC0, 8'hF7));
			while (lead inside {[LEAD_SYMBOLS:LEAD_LATIN_A_HIGH], LEAD_PUNCT, LEAD_EMOJI})
				lead = 8'($urandom_range(8'hC0, 8'hF7));
			draft.push_back(lead);
			n = (lead[7:5] == 3'b110) ? 1 : (lead[7:4] == 4'hE) ? 2 : 3;
			repeat (n) draft.push_back(8'($urandom_range(255)));
		end else if (pick < 80) begin
			// stray byte, a run of high-bit bytes, usually ended by ASCII
			draft.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF)) :
				8'($urandom_range(8'hF8, 8'hFF)));
			repeat ($urandom_range(3)) draft.push_back(8'($urandom_range(8'h80, 8'hFF)));
			if ($urandom_range(99) < 80)
				draft.push_back(8'($urandom_range(127)));
		end else if (pick < 92) begin
			// message ends before the sequence is complete
			draft_known_sequence();
			keep = $urandom_range(1, draft.size() - 1);
			while (draft.size() > keep) void'(draft.pop_back());
			force_last = 1'b1;
		end else begin
			draft.push_back(8'($urandom_range(255)));
		end
		foreach (draft[i]) begin
			item.data = draft[i];
			item.is_last = (i == draft.size() - 1) &&
				(force_last || $urandom_range(99) < 20);
			byte_plan.push_back(item);
		end
	endtask

	task automatic run_random(input int target);
		int         start_count;
		plan_item_t item;
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			plan_sequence();
			while (byte_plan.size() > 0) begin
				item = byte_plan.pop_front();
				send_item(item.data, item.is_last);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_in = 8'h00;
		byte_ch.msg_last = 1'b0;
		stall_request = 1'b0;
		stuck_cycles = 0;
		items_sent = 0;
		src_idle_pct = 22;
		rcv_idle_pct = 66;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: control codes, the C2, C3, E2 and F0 tables, unsupported leads, strays, short ends
		send_item(ASCII_NUL, 1'b0);
		send_item(ASCII_LF, 1'b0);
		send_item(8'h1F, 1'b0);
		send_item(LEAD_LATIN1, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(LEAD_SYMBOLS, 1'b0);
		send_item(8'hB0, 1'b0);
		send_item(LEAD_PUNCT, 1'b0);
		send_item(8'h82, 1'b0);
		send_item(8'hAC, 1'b0);
		send_item(LEAD_EMOJI, 1'b0);
		send_item(8'h9F, 1'b0);
		send_item(8'h90, 1'b0);
		send_item(8'hB1, 1'b1);
		send_item(8'hC0, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'hE5, 1'b0);
		send_item(8'h05, 1'b1);
		send_item(8'hF5, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(LEAD_LATIN1, 1'b1);
		send_item(LEAD_EMOJI, 1'b1);

		// Random, first setting: receiver holds off long while bytes keep coming
		stall_request = 1'b1;
		run_random(PHASE_ITEMS);
		wait_for_drain();

		// Random, sender slow and receiver eager
		src_idle_pct = 66;
		rcv_idle_pct = 22;
		run_random(PHASE_ITEMS);

		// Random, back to back on both sides
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random(PHASE_ITEMS);

		// Drain and let any late transaction show up
		byte_ch.valid <= 1'b0;
		while (glyph_model.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (glyph_model.error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/u2g_pkg.sv
rtl/u2g_byte_if.sv
rtl/u2g_glyph_if.sv
rtl/u2g_decode.sv
rtl/utf8_to_glyph_code_mapper.sv
sim/tb_utf8_to_glyph_code_mapper.sv
